// File: sv/rbia_pkg.sv
// ----------------------------------------------------------------------------
// rbia_pkg
// Shared types and constants of the range bitmap identifier allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rbia_pkg;

  localparam int ID_W      = 8;
  localparam int ID_SPACE  = 256;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = ID_SPACE / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CMD_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR      = 3'd0,
    CMD_ALLOC      = 3'd1,
    CMD_RESERVE    = 3'd2,
    CMD_FREE       = 3'd3,
    CMD_QUERY_USED = 3'd4,
    CMD_QUERY_ELIG = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    REG_BASE  = 2'd0,
    REG_LIMIT = 2'd1,
    REG_EXCL  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0] base;
    logic [ID_W-1:0] limit;
    logic [ID_W-1:0] excl;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic             ok;
    logic [ID_W-1:0]  id_out;
  } token_t;

endpackage

`default_nettype wire

// File: sv/range_bitmap_id_allocator_top.sv
// ----------------------------------------------------------------------------
// range_bitmap_id_allocator_top
// Identifier allocator over a configured range, built as a chain of cells.
// ----------------------------------------------------------------------------
// The block takes one command transaction at a time and returns exactly one
// result transaction for it. The used bitmap is split over a row of cells of
// 64 bits each; the command travels down the row, registered in each cell,
// and the next command is taken only once the result of the last one has
// been delivered. The length of the cell chain and any stall on the result
// stream set how often commands are taken.
`default_nettype none

module range_bitmap_id_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Command stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [2:0] command, [10:3] id_in, rest zero
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [0] ok, [8:1] id_out, rest zero
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int NW = rbia_pkg::NUM_WORDS;

  rbia_pkg::cfg_t   cfg;
  logic             inflight;
  logic             tok_v [NW+1];
  rbia_pkg::token_t tok   [NW+1];
  rbia_pkg::token_t entry_tok;
  logic             s_acc;
  logic [rbia_pkg::CMD_W-1:0] in_cmd;
  logic [rbia_pkg::ID_W-1:0]  in_id;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base  <= rbia_pkg::ID_W'(48);
      cfg.limit <= rbia_pkg::ID_W'(239);
      cfg.excl  <= rbia_pkg::ID_W'(128);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        rbia_pkg::REG_BASE:  cfg.base  <= pwdata[7:0];
        rbia_pkg::REG_LIMIT: cfg.limit <= pwdata[7:0];
        rbia_pkg::REG_EXCL:  cfg.excl  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      rbia_pkg::REG_BASE:  prdata = {24'd0, cfg.base};
      rbia_pkg::REG_LIMIT: prdata = {24'd0, cfg.limit};
      rbia_pkg::REG_EXCL:  prdata = {24'd0, cfg.excl};
      default:             prdata = '0;
    endcase
  end

  assign s_tready = !inflight && !m_tvalid;
  assign s_acc    = s_tvalid && s_tready;
  assign in_cmd   = s_tdata[2:0];
  assign in_id    = s_tdata[10:3];

  always_comb begin
    entry_tok.cmd = in_cmd;
    entry_tok.id  = in_id;
    entry_tok.ok  = 1'b0;
    if (in_cmd == rbia_pkg::CMD_CLEAR) begin
      entry_tok.ok     = 1'b1;
      entry_tok.id_out = '0;
    end else if (in_cmd == rbia_pkg::CMD_ALLOC) begin
      entry_tok.id_out = '0;
    end else begin
      entry_tok.id_out = in_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_v[0] <= 1'b0;
      inflight <= 1'b0;
    end else begin
      tok_v[0] <= s_acc;
      if (s_acc) begin
        inflight <= 1'b1;
      end else if (tok_v[NW]) begin
        inflight <= 1'b0;
      end
    end
    tok[0] <= entry_tok;
  end

  for (genvar k = 0; k < NW; k++) begin : g_cell
    rbia_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .word_base     ((rbia_pkg::ID_W+1)'(k * rbia_pkg::WORD_BITS)),
      .cfg           (cfg),
      .tok_in_valid  (tok_v[k]),
      .tok_in        (tok[k]),
      .tok_out_valid (tok_v[k+1]),
      .tok_out       (tok[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (tok_v[NW]) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (tok_v[NW]) begin
      m_tdata <= {7'd0, tok[NW].id_out, tok[NW].ok};
    end
  end

endmodule

`default_nettype wire

// File: sv/rbia_cell.sv
// ----------------------------------------------------------------------------
// rbia_cell
// One word of the used bitmap; acts on the command token as it passes by.
// ----------------------------------------------------------------------------
`default_nettype none

module rbia_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [rbia_pkg::ID_W:0]  word_base,
  input  wire rbia_pkg::cfg_t           cfg,
  input  wire logic                     tok_in_valid,
  input  wire rbia_pkg::token_t         tok_in,
  output logic                          tok_out_valid,
  output rbia_pkg::token_t              tok_out
);

  logic [rbia_pkg::WORD_BITS-1:0] word;
  logic [rbia_pkg::WORD_BITS-1:0] word_next;
  logic [rbia_pkg::WORD_BITS-1:0] elig;
  logic [rbia_pkg::WORD_BITS-1:0] free_bits;
  logic [rbia_pkg::WORD_BITS-1:0] first_free;
  logic [rbia_pkg::BIT_W-1:0]     first_idx;
  logic [rbia_pkg::BIT_W-1:0]     tgt_bit;
  logic                           hit;
  logic [rbia_pkg::ID_W:0]        bit_id;
  rbia_pkg::token_t               tok_next;

  always_comb begin
    for (int i = 0; i < rbia_pkg::WORD_BITS; i++) begin
      bit_id  = word_base + (rbia_pkg::ID_W+1)'(i);
      elig[i] = (bit_id < (rbia_pkg::ID_W+1)'(rbia_pkg::ID_SPACE)) &&
                (bit_id >= {1'b0, cfg.base}) && (bit_id <= {1'b0, cfg.limit}) &&
                (bit_id != {1'b0, cfg.excl});
    end
  end

  assign free_bits  = elig & ~word;
  assign first_free = free_bits & (~free_bits + 1'b1);

  always_comb begin
    first_idx = '0;
    for (int b = 0; b < rbia_pkg::BIT_W; b++) begin
      for (int i = 0; i < rbia_pkg::WORD_BITS; i++) begin
        if (((i >> b) & 1) == 1) begin
          first_idx[b] = first_idx[b] | first_free[i];
        end
      end
    end
  end

  assign hit     = (({1'b0, tok_in.id} >> rbia_pkg::BIT_W) == (word_base >> rbia_pkg::BIT_W));
  assign tgt_bit = tok_in.id[rbia_pkg::BIT_W-1:0];

  always_comb begin
    word_next = word;
    tok_next  = tok_in;
    if (tok_in_valid) begin
      unique case (rbia_pkg::cmd_t'(tok_in.cmd))
        rbia_pkg::CMD_CLEAR: begin
          word_next = '0;
        end
        rbia_pkg::CMD_ALLOC: begin
          if (!tok_in.ok && (|free_bits)) begin
            word_next       = word | first_free;
            tok_next.ok     = 1'b1;
            tok_next.id_out = word_base[rbia_pkg::ID_W-1:0] +
                              rbia_pkg::ID_W'(first_idx);
          end
        end
        rbia_pkg::CMD_RESERVE: begin
          if (hit && elig[tgt_bit] && !word[tgt_bit]) begin
            word_next[tgt_bit] = 1'b1;
            tok_next.ok        = 1'b1;
          end
        end
        rbia_pkg::CMD_FREE: begin
          if (hit && elig[tgt_bit] && word[tgt_bit]) begin
            word_next[tgt_bit] = 1'b0;
            tok_next.ok        = 1'b1;
          end
        end
        rbia_pkg::CMD_QUERY_USED: begin
          if (hit) begin
            tok_next.ok = elig[tgt_bit] && word[tgt_bit];
          end
        end
        rbia_pkg::CMD_QUERY_ELIG: begin
          if (hit) begin
            tok_next.ok = elig[tgt_bit];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word          <= '0;
      tok_out_valid <= 1'b0;
    end else begin
      word          <= word_next;
      tok_out_valid <= tok_in_valid;
    end
    tok_out <= tok_next;
  end

endmodule

`default_nettype wire

// File: sv/rbia_checker.sv
// ----------------------------------------------------------------------------
// rbia_checker
// Port-level checks of the allocator's transaction ordering.
// ----------------------------------------------------------------------------
`default_nettype none

module rbia_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("command taken while another is in flight");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !m_tvalid)
    else $error("result appeared right after the command");

  a_result_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("command accepted while a result is pending");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind range_bitmap_id_allocator_top rbia_checker u_rbia_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/range_bitmap_id_allocator_checker.sv
// ----------------------------------------------------------------------------
// range_bitmap_id_allocator_checker
// Watches the command, result and register channels of the allocator, keeps
// its own copy of the range registers and the used bitmap, predicts the
// result of every accepted command and compares each result transaction,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module range_bitmap_id_allocator_checker
  import rbia_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,    // [2:0] command, [10:3] id_in, rest zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,    // [0] ok, [8:1] id_out, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          outstanding,
  output int          mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            ok;
    logic [ID_W-1:0] id;
  } alloc_result_t;

  localparam cfg_t CFG_AT_RESET = '{base: 8'd48, limit: 8'd239, excl: 8'd128};

  cfg_t                cfg = CFG_AT_RESET;
  logic [ID_SPACE-1:0] used_map = '0;
  alloc_result_t       expected_results[$];

  initial begin
    outstanding    = 0;
    mismatch_count = 0;
  end

  function automatic logic is_eligible(input int id);
    return id < ID_SPACE && id >= int'(cfg.base) && id <= int'(cfg.limit) &&
           id != int'(cfg.excl);
  endfunction

  function automatic alloc_result_t predict_allocation(input logic [CMD_W-1:0] cmd,
                                                      input logic [ID_W-1:0] id);
    alloc_result_t res;
    logic          found;
    res.ok = 1'b0;
    res.id = id;
    found  = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        used_map = '0;
        res.ok   = 1'b1;
        res.id   = '0;
      end
      CMD_ALLOC: begin
        res.id = '0;
        for (int i = 0; i < ID_SPACE && !found; i++) begin
          if (is_eligible(i) && !used_map[i]) begin
            used_map[i] = 1'b1;
            res.ok      = 1'b1;
            res.id      = i[ID_W-1:0];
            found       = 1'b1;
          end
        end
      end
      CMD_RESERVE: begin
        if (is_eligible(int'(id)) && !used_map[id]) begin
          used_map[id] = 1'b1;
          res.ok       = 1'b1;
        end
      end
      CMD_FREE: begin
        if (is_eligible(int'(id)) && used_map[id]) begin
          used_map[id] = 1'b0;
          res.ok       = 1'b1;
        end
      end
      CMD_QUERY_USED: res.ok = is_eligible(int'(id)) && used_map[id];
      CMD_QUERY_ELIG: res.ok = is_eligible(int'(id));
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    alloc_result_t seen;
    alloc_result_t want;
    if (rst) begin
      cfg      = CFG_AT_RESET;
      used_map = '0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.ok = m_tdata[0];
        seen.id = m_tdata[8:1];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: ok=%0d id_out=%0d", $time, seen.ok, seen.id);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (seen.ok !== want.ok) begin
            $display("%0t: ok expected %0d, got %0d", $time, want.ok, seen.ok);
            mismatch_count++;
          end
          if (seen.id !== want.id) begin
            $display("%0t: id_out expected %0d, got %0d", $time, want.id, seen.id);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(predict_allocation(s_tdata[2:0], s_tdata[10:3]));
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BASE:  cfg.base  = pwdata[7:0];
          REG_LIMIT: cfg.limit = pwdata[7:0];
          REG_EXCL:  cfg.excl  = pwdata[7:0];
          default: ;
        endcase
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// File: tb/tb_range_bitmap_id_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_range_bitmap_id_allocator_top
// Drives the allocator with a directed set of commands and then with phases
// of random commands under a series of range settings, with random gaps on
// both streams. The checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_range_bitmap_id_allocator_top;
  import rbia_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               NUM_PHASES      = 12;
  localparam int               ITEMS_PER_PHASE = 128;
  localparam int               STALL_LIMIT     = 1000;
  localparam int               DRAIN_CYCLES    = 20;
  localparam logic [1:0]       REG_NONE        = 2'd3;
  localparam logic [CMD_W-1:0] CMD_BAD_LO      = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BAD_HI      = 3'd7;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [2:0] command, [10:3] id_in, rest zero
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [0] ok, [8:1] id_out, rest zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int outstanding;
  int mismatch_count;
  bit burst_mode = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  range_bitmap_id_allocator_top u_top (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  range_bitmap_id_allocator_checker u_checker (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .outstanding, .mismatch_count
  );

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, id, cmd};
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [ID_W-1:0] value);
    logic [31:0] noise;
    noise   = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {noise[31:8], value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("range_bitmap_id_allocator_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    int               pick;
    int               lo;
    int               hi;
    int               lo_near;
    int               hi_near;
    int               hot_top;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [ID_W-1:0]  base;
    logic [ID_W-1:0]  limit;
    logic [ID_W-1:0]  excl;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_command(CMD_QUERY_ELIG, 8'd0);
    send_command(CMD_QUERY_ELIG, 8'd47);
    send_command(CMD_QUERY_ELIG, 8'd48);
    send_command(CMD_QUERY_ELIG, 8'd128);
    send_command(CMD_QUERY_ELIG, 8'd239);
    send_command(CMD_QUERY_ELIG, 8'd240);
    send_command(CMD_QUERY_ELIG, 8'd255);
    send_command(CMD_ALLOC, 8'hFF);
    send_command(CMD_ALLOC, 8'h00);
    send_command(CMD_RESERVE, 8'd128);
    send_command(CMD_RESERVE, 8'd48);
    send_command(CMD_RESERVE, 8'd255);
    send_command(CMD_RESERVE, 8'd200);
    send_command(CMD_FREE, 8'd200);
    send_command(CMD_FREE, 8'd200);
    send_command(CMD_FREE, 8'd0);
    send_command(CMD_QUERY_USED, 8'd48);
    send_command(CMD_QUERY_USED, 8'd0);
    send_command(CMD_BAD_LO, 8'hAA);
    send_command(CMD_BAD_HI, 8'h55);
    send_command(CMD_CLEAR, 8'hFF);
    send_command(CMD_QUERY_USED, 8'd48);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin base = 8'd0;   limit = 8'd255; excl = 8'd0;   end
        1: begin base = 8'd0;   limit = 8'd255; excl = 8'd255; end
        2: begin base = 8'd100; limit = 8'd107; excl = 8'd104; end
        3: begin base = 8'd200; limit = 8'd100; excl = 8'd150; end
        4: begin base = 8'd5;   limit = 8'd5;   excl = 8'd5;   end
        5: begin base = 8'd60;  limit = 8'd70;  excl = 8'd200; end
        6: begin base = 8'd255; limit = 8'd255; excl = 8'd0;   end
        default: begin
          base  = ID_W'($urandom_range(0, 255));
          limit = ID_W'($urandom_range(0, 255));
          excl  = ID_W'($urandom_range(0, 255));
        end
      endcase
      write_register(REG_BASE, base);
      write_register(REG_LIMIT, limit);
      write_register(REG_EXCL, excl);
      if (phase == 3)
        write_register(REG_NONE, ID_W'($urandom_range(0, 255)));

      lo      = (base < limit) ? int'(base) : int'(limit);
      hi      = (base < limit) ? int'(limit) : int'(base);
      lo_near = (lo >= 2) ? lo - 2 : 0;
      hi_near = (hi <= 253) ? hi + 2 : 255;
      hot_top = (lo + 15 > 255) ? 255 : lo + 15;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 32 == 0)
          burst_mode = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 30)      cmd = CMD_ALLOC;
        else if (pick < 50) cmd = CMD_RESERVE;
        else if (pick < 70) cmd = CMD_FREE;
        else if (pick < 80) cmd = CMD_QUERY_USED;
        else if (pick < 90) cmd = CMD_QUERY_ELIG;
        else if (pick < 92) cmd = CMD_CLEAR;
        else if (pick < 95) cmd = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
        else                cmd = CMD_W'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 7) begin
          if ((cmd == CMD_FREE || cmd == CMD_QUERY_USED) && $urandom_range(0, 1) == 1)
            id = ID_W'($urandom_range(lo, hot_top));
          else
            id = ID_W'($urandom_range(lo_near, hi_near));
        end else begin
          id = ID_W'($urandom_range(0, 255));
        end
        send_command(cmd, id);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("range_bitmap_id_allocator_top: match");
    else
      $display("range_bitmap_id_allocator_top: mismatch");
    $finish;
  end

endmodule

// File: sim.f
sv/rbia_pkg.sv
sv/rbia_cell.sv
sv/range_bitmap_id_allocator_top.sv
sv/rbia_checker.sv
tb/range_bitmap_id_allocator_checker.sv
tb/tb_range_bitmap_id_allocator_top.sv
